[src/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the dense-graph shortest path engine: beat
// layouts of both channels, controller states and operation codes.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int VID_W      = 6;
	localparam int W_W        = 16;
	localparam int DIST_W     = 22;
	localparam int VC_W       = 7;
	localparam int PATH_DEPTH = 64;
	localparam int PATH_AW    = 6;
	localparam int PATH_CW    = 7;

	localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;
	localparam logic [VC_W-1:0]   VC_RESET = 7'd64;

	localparam logic OP_EDGE  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [VID_W-1:0] edge_from;
		logic [VID_W-1:0] edge_to;
		logic [W_W-1:0]   weight;
		logic [VID_W-1:0] source;
		logic [VID_W-1:0] target;
	} item_t;

	typedef struct packed {
		logic [VID_W-1:0]  path_vertex;
		logic [DIST_W-1:0] distance;
		logic              reachable;
		logic              last;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROUND,
		ST_SEL,
		ST_RELAX,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_MISS
	} state_t;

endpackage

[src/spd_edge_store.sv]
// ----------------------------------------------------------------------------
// spd_edge_store
// Adjacency matrix of edge weights, addressed {tail, head}. One write port,
// one registered read port. Sweeps every entry to zero after reset.
// ----------------------------------------------------------------------------
module spd_edge_store
	import spd_pkg::*;
#(
	parameter int VW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [2*VW-1:0] wr_addr,
	input  logic [W_W-1:0]  wr_data,
	input  logic [2*VW-1:0] rd_addr,
	output logic [W_W-1:0]  rd_data,
	output logic            clear_done
);

	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;

	logic [W_W-1:0] mem [DEPTH];
	logic [AW:0]    clr_q;

	assign clear_done = clr_q[AW];

	// advance the clearing sweep until every entry has been zeroed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[AW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// write port: clearing sweep first, then edge writes
	always_ff @(posedge clk) begin
		if (!clr_q[AW]) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[src/spd_engine.sv]
// ----------------------------------------------------------------------------
// spd_engine
// Search sequencer: vertex memory (distance and parent), reached and settled
// bits, selection scan, relaxation scan, parent walk into the path store and
// the result register.
// ----------------------------------------------------------------------------
module spd_engine
	import spd_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int VW           = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [VC_W-1:0] vertex_count,
	input  logic            item_valid,
	output logic            item_stall,
	input  item_t           item,
	output logic            result_valid,
	input  logic            result_stall,
	output result_t         result,
	output logic            e_wr_en,
	output logic [2*VW-1:0] e_wr_addr,
	output logic [W_W-1:0]  e_wr_data,
	output logic [2*VW-1:0] e_rd_addr,
	input  logic [W_W-1:0]  e_rd_data,
	input  logic            clear_done
);

	localparam int NW = VW + 1;
	localparam int VM_W = VW + DIST_W;

	state_t state_q, state_d;

	// vertex memory word: {parent, distance}
	logic [VM_W-1:0]   vmem [MAX_VERTICES];
	logic [VM_W-1:0]   vm_rd;
	logic              vm_we;
	logic [VW-1:0]     vm_waddr, vm_raddr;
	logic [VM_W-1:0]   vm_wdata;
	logic [VW-1:0]     vm_rd_pred;
	logic [DIST_W-1:0] vm_rd_dist;

	logic [VID_W-1:0]  pstore [PATH_DEPTH];
	logic [VID_W-1:0]  ps_rd;

	logic [MAX_VERTICES-1:0] reached_q, settled_q;
	logic [VW-1:0]     src_q, dst_q, best_q, u_q, v_q, i_s1;
	logic [VID_W-1:0]  tgt_q;
	logic [NW-1:0]     n_q, rnd_q, idx_q, n_eff;
	logic [DIST_W-1:0] best_d_q, du_q, dist_q;
	logic              have_q, vld_s1;
	logic [PATH_CW-1:0] k_q;

	logic              accept, q_ok, issue, scan_end, out_free, relax_upd;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] sat;
	logic              out_valid_q;
	result_t           out_q;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;

	// clamp the vertex count into 1..MAX_VERTICES
	always_comb begin
		if (vertex_count == '0) begin
			n_eff = NW'(1);
		end else if (int'(vertex_count) > MAX_VERTICES) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vertex_count);
		end
	end
	assign q_ok = (int'(item.source) < int'(n_eff)) && (int'(item.target) < int'(n_eff));

	// edge writes go straight to the matrix
	assign e_wr_en   = accept && (item.opcode == OP_EDGE)
		&& (int'(item.edge_from) < MAX_VERTICES) && (int'(item.edge_to) < MAX_VERTICES);
	assign e_wr_addr = {VW'(item.edge_from), VW'(item.edge_to)};
	assign e_wr_data = item.weight;
	assign e_rd_addr = {u_q, idx_q[VW-1:0]};

	assign issue    = (idx_q < n_q);
	assign scan_end = !issue && !vld_s1;
	assign vm_raddr = (state_q == ST_WALK_RD) ? v_q : idx_q[VW-1:0];
	assign vm_rd_pred = vm_rd[VM_W-1:DIST_W];
	assign vm_rd_dist = vm_rd[DIST_W-1:0];

	// relax one edge: saturating sum, update when unreached or shorter
	assign sum = {1'b0, du_q} + (DIST_W+1)'(e_rd_data);
	assign sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	assign relax_upd = vld_s1 && (state_q == ST_RELAX) && !settled_q[i_s1]
		&& (e_rd_data != '0) && (!reached_q[i_s1] || sat < vm_rd_dist);

	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = i_s1;
		vm_wdata = {u_q, sat};
		if (accept && item.opcode == OP_QUERY && q_ok) begin
			vm_we    = 1'b1;
			vm_waddr = VW'(item.source);
			vm_wdata = '0;
		end else if (relax_upd) begin
			vm_we = 1'b1;
		end
	end

	// vertex memory
	always_ff @(posedge clk) begin
		if (vm_we) begin
			vmem[vm_waddr] <= vm_wdata;
		end
		vm_rd <= vmem[vm_raddr];
	end

	// path store
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK_WR) begin
			pstore[k_q[PATH_AW-1:0]] <= VID_W'(v_q);
		end
		ps_rd <= pstore[PATH_AW'(k_q - 1'b1)];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && item.opcode == OP_QUERY) begin
					state_d = q_ok ? ST_ROUND : ST_MISS;
				end
			end
			ST_ROUND: begin
				if ((NW+1)'(rnd_q) + 1'b1 < (NW+1)'(n_q)) begin
					state_d = ST_SEL;
				end else begin
					state_d = reached_q[dst_q] ? ST_WALK_RD : ST_MISS;
				end
			end
			ST_SEL: begin
				if (scan_end) state_d = reached_q[best_q] ? ST_RELAX : ST_ROUND;
			end
			ST_RELAX: begin
				if (scan_end) state_d = ST_ROUND;
			end
			ST_WALK_RD: state_d = ST_WALK_WR;
			ST_WALK_WR: begin
				if (v_q == src_q || int'(k_q) == PATH_DEPTH - 1) begin
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: begin
				if (out_free) state_d = (k_q == PATH_CW'(1)) ? ST_IDLE : ST_EMIT_RD;
			end
			ST_MISS: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// search control and vertex flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			settled_q <= '0;
			vld_s1    <= 1'b0;
			idx_q     <= '0;
			rnd_q     <= '0;
			have_q    <= 1'b0;
			k_q       <= '0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && item.opcode == OP_QUERY && q_ok) begin
						reached_q <= '0;
						reached_q[VW'(item.source)] <= 1'b1;
						settled_q <= '0;
						rnd_q     <= '0;
					end
				end
				ST_ROUND: begin
					idx_q  <= '0;
					have_q <= 1'b0;
					k_q    <= '0;
				end
				ST_SEL: begin
					if (issue) begin
						idx_q  <= idx_q + 1'b1;
						vld_s1 <= 1'b1;
					end
					// keep the best candidate: reached beats unreached, ties to highest
					if (vld_s1 && !settled_q[i_s1]) begin
						if (reached_q[i_s1] && (!have_q || vm_rd_dist <= best_d_q)) begin
							have_q <= 1'b1;
						end
					end
					if (scan_end) begin
						settled_q[best_q] <= 1'b1;
						rnd_q <= rnd_q + 1'b1;
						idx_q <= '0;
					end
				end
				ST_RELAX: begin
					if (issue) begin
						idx_q  <= idx_q + 1'b1;
						vld_s1 <= 1'b1;
					end
					if (relax_upd) reached_q[i_s1] <= 1'b1;
				end
				ST_WALK_WR: k_q <= k_q + 1'b1;
				ST_EMIT_LD: begin
					if (out_free) k_q <= k_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// search payload registers
	always_ff @(posedge clk) begin
		i_s1 <= idx_q[VW-1:0];
		if (accept && item.opcode == OP_QUERY) begin
			src_q <= VW'(item.source);
			dst_q <= VW'(item.target);
			tgt_q <= item.target;
			n_q   <= n_eff;
		end
		if (state_q == ST_ROUND) begin
			best_q <= '0;
			v_q    <= dst_q;
		end
		if (state_q == ST_SEL && vld_s1 && !settled_q[i_s1]) begin
			if (reached_q[i_s1] && (!have_q || vm_rd_dist <= best_d_q)) begin
				best_q   <= i_s1;
				best_d_q <= vm_rd_dist;
			end else if (!reached_q[i_s1] && !have_q) begin
				best_q <= i_s1;
			end
		end
		if (state_q == ST_SEL && scan_end) begin
			u_q  <= best_q;
			du_q <= best_d_q;
		end
		if (state_q == ST_WALK_WR) begin
			if (k_q == '0) dist_q <= vm_rd_dist;
			v_q <= vm_rd_pred;
		end
	end

	// result register: load when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT_LD || state_q == ST_MISS) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD && out_free) begin
			out_q.path_vertex <= ps_rd;
			out_q.distance    <= dist_q;
			out_q.reachable   <= 1'b1;
			out_q.last        <= (k_q == PATH_CW'(1));
		end else if (state_q == ST_MISS && out_free) begin
			out_q.path_vertex <= tgt_q;
			out_q.distance    <= '0;
			out_q.reachable   <= 1'b0;
			out_q.last        <= 1'b1;
		end
	end

endmodule

[src/shortest_path_dense_graph_top.sv]
// ----------------------------------------------------------------------------
// shortest_path_dense_graph_top
// Dijkstra shortest path engine over a dense adjacency matrix.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall/item): an edge beat stores one weight
// into the matrix; a query beat runs a search from source and answers on the
// result channel with the path, source first, one beat per vertex, the final
// beat flagged last. An unreachable target or an out-of-range source or
// target gives one beat with reachable low. A query runs n-1 search rounds,
// where n is the vertex count in use: each round starts, scans the vertex
// memory to select and, if the selected vertex is reached, scans the memory
// again alongside the matrix row to relax. Then come the parent walk and the
// result beats. Items are taken one at a time; the next is taken once the
// final result is in the output register.
// After reset the matrix is swept to zero, one entry a cycle; item_stall is
// high meanwhile. A stalled result holds in the output register and the
// engine waits. The user must write vertex_count through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph_top
	import spd_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [VC_W-1:0] cfg_wdata,
	input  logic            item_valid,
	output logic            item_stall,
	input  item_t           item,
	output logic            result_valid,
	input  logic            result_stall,
	output result_t         result
);

	localparam int VW = $clog2(MAX_VERTICES);

	logic [VC_W-1:0] vertex_count_q;
	logic            e_wr_en, clear_done;
	logic [2*VW-1:0] e_wr_addr, e_rd_addr;
	logic [W_W-1:0]  e_wr_data, e_rd_data;

	// hold the vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	spd_edge_store #(.VW(VW)) u_edges (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (e_wr_en),
		.wr_addr    (e_wr_addr),
		.wr_data    (e_wr_data),
		.rd_addr    (e_rd_addr),
		.rd_data    (e_rd_data),
		.clear_done (clear_done)
	);

	spd_engine #(.MAX_VERTICES(MAX_VERTICES), .VW(VW)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_count (vertex_count_q),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.e_wr_en      (e_wr_en),
		.e_wr_addr    (e_wr_addr),
		.e_wr_data    (e_wr_data),
		.e_rd_addr    (e_rd_addr),
		.e_rd_data    (e_rd_data),
		.clear_done   (clear_done)
	);

	// no beat taken while the matrix is being cleared
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> item_stall)
		else $error("item taken during clearing pass");

	// no edge write lands during the clearing pass
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		e_wr_en |-> clear_done)
		else $error("edge write during clearing pass");

	// a query keeps the input side busy on the following cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.opcode == OP_QUERY) |=> item_stall)
		else $error("query did not hold the input side");

	// an unreachable answer is always a single beat
	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.reachable) |-> result.last)
		else $error("unreachable result not flagged last");

endmodule

[sim/shortest_path_dense_graph_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shortest_path_dense_graph_top_test
// Self-checking bench for the shortest path engine. A directed table of edge
// and query beats, then random graph phases at several vertex counts. Every
// accepted query is predicted by an in-bench Dijkstra search and each result
// beat is checked per field. Both channels idle at random in most phases.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph_top_test;
	import spd_pkg::*;

	localparam int NV        = 64;
	localparam int QUIET_MAX = 60000;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic [VC_W-1:0] cfg_wdata;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// graph mirror and path expectations
	logic [W_W-1:0]    edge_mem [NV*NV];
	logic [VC_W-1:0]   vcount_reg;
	result_t           path_beats [$];
	int                mismatches;
	int                quiet_cycles;
	bit                no_idle;

	row_t directed_rows [17] = '{
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd0, 6'd63}, 1,
			result_t'{6'd63, 22'd0, 1'b0, 1'b1}},
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd7, 6'd7}, 1,
			result_t'{6'd7, 22'd0, 1'b1, 1'b1}},
		'{item_t'{OP_EDGE, 6'd63, 6'd0, 16'hFFFF, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd63, 6'd0}, 0, '0},
		'{item_t'{OP_EDGE, 6'd0, 6'd63, 16'd1, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd0, 6'd63}, 0, '0},
		'{item_t'{OP_EDGE, 6'd0, 6'd63, 16'd0, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd0, 6'd63}, 1,
			result_t'{6'd63, 22'd0, 1'b0, 1'b1}},
		'{item_t'{OP_EDGE, 6'd1, 6'd2, 16'd5, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_EDGE, 6'd2, 6'd3, 16'd5, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_EDGE, 6'd1, 6'd3, 16'd10, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd1, 6'd3}, 0, '0},
		'{item_t'{OP_EDGE, 6'd3, 6'd4, 16'hFFFF, 6'd0, 6'd0}, 0, '0},
		'{item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd1, 6'd4}, 0, '0},
		'{item_t'{OP_EDGE, 6'd42, 6'd21, 16'h5555, 6'h2A, 6'h15}, 0, '0},
		'{item_t'{OP_EDGE, 6'd21, 6'd42, 16'hAAAA, 6'h15, 6'h2A}, 0, '0},
		'{item_t'{OP_QUERY, 6'h2A, 6'h15, 16'hFFFF, 6'd21, 6'd42}, 0, '0}
	};

	shortest_path_dense_graph_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// Dijkstra over the mirrored matrix; append the expected path beats
	function automatic void predict_path(item_t it);
		int unsigned n, u, v, k, best_d, sum;
		int unsigned dist_v [NV];
		int          pred [NV];
		bit          seen [NV];
		bit          done [NV];
		bit          have;
		int          trail [$];
		result_t     r;
		if (it.opcode == OP_EDGE) begin
			edge_mem[it.edge_from*NV + it.edge_to] = it.weight;
			return;
		end
		n = (vcount_reg == 0) ? 1 : (vcount_reg > NV) ? NV : vcount_reg;
		if (it.source >= n || it.target >= n) begin
			path_beats.push_back(result_t'{it.target, 22'd0, 1'b0, 1'b1});
			return;
		end
		for (v = 0; v < NV; v++) begin
			dist_v[v] = 0; pred[v] = -1; seen[v] = 0; done[v] = 0;
		end
		seen[it.source] = 1;
		for (int rnd = 0; rnd + 1 < n; rnd++) begin
			// select: reached beats unreached, ties to the highest index
			u = 0; have = 0; best_d = 0;
			for (v = 0; v < n; v++) begin
				if (done[v])
					continue;
				if (seen[v]) begin
					if (!have || dist_v[v] <= best_d) begin
						u = v; best_d = dist_v[v]; have = 1;
					end
				end else if (!have) begin
					u = v;
				end
			end
			done[u] = 1;
			if (!seen[u])
				continue;
			// relax outgoing edges with saturation
			for (v = 0; v < n; v++) begin
				if (done[v] || edge_mem[u*NV + v] == 0)
					continue;
				sum = dist_v[u] + edge_mem[u*NV + v];
				if (sum > DIST_MAX)
					sum = DIST_MAX;
				if (!seen[v] || sum < dist_v[v]) begin
					dist_v[v] = sum; seen[v] = 1; pred[v] = u;
				end
			end
		end
		if (!seen[it.target]) begin
			path_beats.push_back(result_t'{it.target, 22'd0, 1'b0, 1'b1});
			return;
		end
		v = it.target;
		for (k = 0; k < PATH_DEPTH; k++) begin
			trail.push_front(v);
			if (pred[v] < 0)
				break;
			v = pred[v];
		end
		foreach (trail[i]) begin
			r.path_vertex = VID_W'(trail[i]);
			r.distance    = DIST_W'(dist_v[it.target]);
			r.reachable   = 1'b1;
			r.last        = (i == trail.size() - 1);
			path_beats.push_back(r);
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// drive one beat on the input channel and hold it until taken
	task automatic send_item(item_t it, bit typed, result_t res);
		int gap;
		result_t scratch [$];
		gap = draw_gap();
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		if (typed) begin
			// keep the mirror in step, then expect the typed beat instead
			scratch = path_beats;
			predict_path(it);
			path_beats = scratch;
			path_beats.push_back(res);
		end else begin
			predict_path(it);
		end
		@(negedge clk);
	endtask

	task automatic write_vcount(logic [VC_W-1:0] value);
		item_valid = 1'b0;
		wait (path_beats.size() == 0);
		repeat (8) @(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		vcount_reg = value;
	endtask

	// result side: random stall per beat, check each accepted beat
	initial begin
		int gap;
		result_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			result_stall = 1'b1;
			repeat (gap) @(negedge clk);
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			if (path_beats.size() == 0) begin
				report_mismatch("unexpected beat, vertex", result.path_vertex, -1);
			end else begin
				if (result.path_vertex != path_beats[0].path_vertex)
					report_mismatch("path_vertex", result.path_vertex,
						path_beats[0].path_vertex);
				if (result.distance != path_beats[0].distance)
					report_mismatch("distance", result.distance, path_beats[0].distance);
				if (result.reachable != path_beats[0].reachable)
					report_mismatch("reachable", result.reachable,
						path_beats[0].reachable);
				if (result.last != path_beats[0].last)
					report_mismatch("last", result.last, path_beats[0].last);
				void'(path_beats.pop_front());
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [VC_W-1:0] phase_counts [8] = '{7'd3, 7'd0, 7'd127, 7'd6, 7'd1,
			7'd10, 7'd64, 7'd8};
		item_t it;
		int unsigned n, span;
		mismatches = 0;
		quiet_cycles = 0;
		no_idle = 0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_valid = 1'b0;
		item = '0;
		vcount_reg = VC_RESET;
		foreach (edge_mem[i])
			edge_mem[i] = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed table at the reset vertex count
		foreach (directed_rows[i])
			send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

		// random phases across vertex counts
		foreach (phase_counts[p]) begin
			write_vcount(phase_counts[p]);
			no_idle = (p % 3 == 2);
			n = (vcount_reg == 0) ? 1 : (vcount_reg > NV) ? NV : vcount_reg;
			for (int j = 0; j < 16; j++) begin
				it = item_t'({$urandom, $urandom});
				span = ($urandom_range(0, 9) == 0) ? NV : n;
				if ($urandom_range(0, 2) != 0) begin
					it.opcode    = OP_EDGE;
					it.edge_from = VID_W'($urandom_range(0, span - 1));
					it.edge_to   = VID_W'($urandom_range(0, span - 1));
					case ($urandom_range(0, 5))
						0: it.weight = '0;
						1: it.weight = 16'hFFFF;
						2: it.weight = W_W'($urandom_range(1, 20));
						default: ;
					endcase
				end else begin
					it.opcode = OP_QUERY;
					it.source = VID_W'($urandom_range(0, span - 1));
					it.target = VID_W'($urandom_range(0, span - 1));
				end
				send_item(it, 1'b0, '0);
			end
		end
		write_vcount(VC_RESET);
		send_item(item_t'{OP_QUERY, 6'd0, 6'd0, 16'd0, 6'd1, 6'd4}, 1'b0, '0);

		item_valid = 1'b0;
		wait (path_beats.size() == 0);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
